// ----- hdl/hsl2rgb_pkg.sv -----
// Package for the HSL to RGB converter: field widths, hue constants and
// the small divide-by-255 helper used by the lightness and saturation scaling.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package hsl2rgb_pkg;

    // Field widths of the input and result transfers.
    localparam int HUE_W   = 13;
    localparam int SAT_W   = 8;
    localparam int LIG_W   = 8;
    localparam int COLOR_W = 8;

    // Default number of fraction bits of the internal fixed-point values.
    localparam int FRACTION_BITS_DEFAULT = 16;

    // Hue units are 1/16 degree: 60 degrees and 120 degrees.
    localparam int HUE_SECTOR = 960;
    localparam int HUE_PAIR   = 1920;

    // Exact floor(y / 255) for y below 65025.
    function automatic logic [7:0] div255(input logic [15:0] y);
        logic [16:0] sum;
        sum = {1'b0, y} + 17'd1 + 17'(y >> 8);
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/hsl2rgb_in_if.sv -----
// Input channel of the HSL to RGB converter: valid/ready plus one HSL triple.
// Depends on hsl2rgb_pkg for the field widths.
`default_nettype none

interface hsl2rgb_in_if
    import hsl2rgb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]   saturation;
    logic [LIG_W-1:0]   lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/hsl2rgb_out_if.sv -----
// Output channel of the HSL to RGB converter: valid/ready plus one RGB triple.
// Depends on hsl2rgb_pkg for the field widths.
`default_nettype none

interface hsl2rgb_out_if
    import hsl2rgb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- hdl/hsl_to_rgb_converter_top.sv -----
// HSL to RGB converter: a nine-stage pipeline from one HSL triple to 8-bit RGB.
// Depends on hsl2rgb_pkg, hsl2rgb_in_if and hsl2rgb_out_if.
//
// Usage:
//   hsl_in carries hue (1/16 degree units), saturation and lightness (x/255).
//   rgb_out carries red, green and blue. A transfer happens on a rising clock
//   edge where valid and ready are both high; each input transfer yields
//   exactly one output transfer, in order.
// Stages, one per step and in order: two steps of the scaling by 1/255,
//   1-|2L-1|, chroma multiply, X multiply, two steps of the divide by 960,
//   channel add, output scale and clamp.
// Throughput: one triple per clock unless stalled; every stage holds one triple.
// Reset: rst_n low empties the pipeline at once; no results are pending after it.
// Stall: when the receiver holds ready low, the last stage keeps its result and
//   upstream stages keep filling any empty stages, so bubbles close up; hsl_in.ready
//   drops only when all nine stages hold a triple.
`default_nettype none

module hsl_to_rgb_converter_top
    import hsl2rgb_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    hsl2rgb_in_if.sink         hsl_in,
    hsl2rgb_out_if.source      rgb_out
);

    localparam int F      = FRACTION_BITS;
    localparam int FW     = F + 1;            // holds 0 .. 1.0
    localparam int WW     = 10;               // holds 0 .. 960
    localparam int XPW    = FW + WW;          // chroma times hue weight
    localparam int YW     = XPW - 6;          // that product divided by 64
    localparam int K      = YW + 4;           // reciprocal shift for divide by 15
    localparam int RW     = YW + 1;           // holds the scaled reciprocal of 15
    localparam int NSTAGE = 9;

    localparam int unsigned DIV_A = (32'd1 << F) / 255;
    localparam int unsigned DIV_B = (32'd1 << F) % 255;
    localparam longint unsigned RECIP15 = (64'd1 << K) / 15;

    localparam logic [FW:0]   ONE_X = (FW+1)'(1) << F;
    localparam logic [FW:0]   TWO_X = (FW+1)'(1) << (F + 1);
    localparam logic [RW-1:0] RECIP = RW'(RECIP15);

    // Hue sector; the names give the colors at its two ends.
    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    // Stage handshake: a stage loads when it is empty or its contents move on.
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] load;

    always_comb
    begin
        load[NSTAGE-1] = ~valid_reg[NSTAGE-1] | rgb_out.ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            load[i] = ~valid_reg[i] | load[i+1];
        end
    end

    assign hsl_in.ready  = load[0];
    assign rgb_out.valid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= hsl_in.valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 1: split x*2^F/255 into x*a + x*b/255, and decode the hue.
    logic [FW-1:0]    sa_next, la_next;
    logic [15:0]      sb_next, lb_next;
    sector_t          sec_next;
    logic [10:0]      k_next;
    logic [WW-1:0]    w_next;

    assign sa_next = FW'(hsl_in.saturation * DIV_A);
    assign la_next = FW'(hsl_in.lightness * DIV_A);
    assign sb_next = 16'(hsl_in.saturation * DIV_B);
    assign lb_next = 16'(hsl_in.lightness * DIV_B);

    always_comb
    begin
        if (hsl_in.hue >= HUE_W'(5 * HUE_SECTOR))
        begin
            sec_next = SEC_M_R;
        end
        else if (hsl_in.hue >= HUE_W'(4 * HUE_SECTOR))
        begin
            sec_next = SEC_B_M;
        end
        else if (hsl_in.hue >= HUE_W'(3 * HUE_SECTOR))
        begin
            sec_next = SEC_C_B;
        end
        else if (hsl_in.hue >= HUE_W'(2 * HUE_SECTOR))
        begin
            sec_next = SEC_G_C;
        end
        else if (hsl_in.hue >= HUE_W'(HUE_SECTOR))
        begin
            sec_next = SEC_Y_G;
        end
        else
        begin
            sec_next = SEC_R_Y;
        end

        // Hue modulo 120 degrees, valid over the whole 13-bit range.
        if (hsl_in.hue >= HUE_W'(4 * HUE_PAIR))
        begin
            k_next = 11'(hsl_in.hue - HUE_W'(4 * HUE_PAIR));
        end
        else if (hsl_in.hue >= HUE_W'(3 * HUE_PAIR))
        begin
            k_next = 11'(hsl_in.hue - HUE_W'(3 * HUE_PAIR));
        end
        else if (hsl_in.hue >= HUE_W'(2 * HUE_PAIR))
        begin
            k_next = 11'(hsl_in.hue - HUE_W'(2 * HUE_PAIR));
        end
        else if (hsl_in.hue >= HUE_W'(HUE_PAIR))
        begin
            k_next = 11'(hsl_in.hue - HUE_W'(HUE_PAIR));
        end
        else
        begin
            k_next = 11'(hsl_in.hue);
        end

        // Weight of X: 960 - |k - 960|.
        if (k_next >= 11'(HUE_SECTOR))
        begin
            w_next = WW'(11'(HUE_PAIR) - k_next);
        end
        else
        begin
            w_next = WW'(k_next);
        end
    end

    logic [FW-1:0]    s1_sa_reg, s1_la_reg;
    logic [15:0]      s1_sb_reg, s1_lb_reg;
    sector_t          s1_sec_reg;
    logic [WW-1:0]    s1_w_reg;

    // Stage 2: finish the scaling of saturation and lightness.
    logic [FW-1:0]    s_next, l_next;

    assign s_next = s1_sa_reg + FW'(div255(s1_sb_reg));
    assign l_next = s1_la_reg + FW'(div255(s1_lb_reg));

    logic [FW-1:0]    s2_s_reg, s2_l_reg;
    sector_t          s2_sec_reg;
    logic [WW-1:0]    s2_w_reg;

    // Stage 3: 1 - |2L - 1|.
    logic [FW:0]      twol;
    logic [FW-1:0]    omt_next;

    assign twol     = {s2_l_reg, 1'b0};
    assign omt_next = (twol <= ONE_X) ? FW'(twol) : FW'(TWO_X - twol);

    logic [FW-1:0]    s3_omt_reg, s3_s_reg, s3_l_reg;
    sector_t          s3_sec_reg;
    logic [WW-1:0]    s3_w_reg;

    // Stage 4: chroma C = (1 - |2L - 1|) * S.
    logic [2*FW-1:0]  cprod;
    logic [FW-1:0]    c_next;

    assign cprod  = (2*FW)'(s3_omt_reg) * (2*FW)'(s3_s_reg);
    assign c_next = FW'(cprod >> F);

    logic [FW-1:0]    s4_c_reg, s4_l_reg;
    sector_t          s4_sec_reg;
    logic [WW-1:0]    s4_w_reg;

    // Stage 5: C times the hue weight, and the offset m = L - C/2.
    logic [XPW-1:0]   xp_next;
    logic [FW-1:0]    half;
    logic [FW-1:0]    m_next;

    assign xp_next = XPW'(s4_c_reg) * XPW'(s4_w_reg);
    assign half    = s4_c_reg >> 1;
    assign m_next  = (s4_l_reg >= half) ? (s4_l_reg - half) : '0;

    logic [XPW-1:0]   s5_xp_reg;
    logic [FW-1:0]    s5_c_reg, s5_m_reg;
    sector_t          s5_sec_reg;

    // Stage 6: divide by 960 as a shift by 6 and a reciprocal multiply by 1/15.
    logic [YW-1:0]    y_next;
    logic [YW+RW-1:0] qprod_next;

    assign y_next     = YW'(s5_xp_reg >> 6);
    assign qprod_next = (YW+RW)'(y_next) * (YW+RW)'(RECIP);

    logic [YW+RW-1:0] s6_qprod_reg;
    logic [YW-1:0]    s6_y_reg;
    logic [FW-1:0]    s6_c_reg, s6_m_reg;
    sector_t          s6_sec_reg;

    // Stage 7: the estimate is low by at most one; correct it from the remainder.
    logic [YW-1:0]    q0;
    logic [YW-1:0]    rem;
    logic [FW-1:0]    x_next;

    assign q0     = YW'(s6_qprod_reg >> K);
    assign rem    = s6_y_reg - ((q0 << 4) - q0);
    assign x_next = (rem >= YW'(15)) ? FW'(q0 + YW'(1)) : FW'(q0);

    logic [FW-1:0]    s7_x_reg, s7_c_reg, s7_m_reg;
    sector_t          s7_sec_reg;

    // Stage 8: place C, X and 0 by sector and add the offset.
    logic [FW-1:0]    r_ch, g_ch, b_ch;
    logic [FW:0]      vr_next, vg_next, vb_next;

    always_comb
    begin
        unique case (s7_sec_reg)
            SEC_R_Y:
            begin
                r_ch = s7_c_reg; g_ch = s7_x_reg; b_ch = '0;
            end
            SEC_Y_G:
            begin
                r_ch = s7_x_reg; g_ch = s7_c_reg; b_ch = '0;
            end
            SEC_G_C:
            begin
                r_ch = '0;       g_ch = s7_c_reg; b_ch = s7_x_reg;
            end
            SEC_C_B:
            begin
                r_ch = '0;       g_ch = s7_x_reg; b_ch = s7_c_reg;
            end
            SEC_B_M:
            begin
                r_ch = s7_x_reg; g_ch = '0;       b_ch = s7_c_reg;
            end
            default:
            begin
                r_ch = s7_c_reg; g_ch = '0;       b_ch = s7_x_reg;
            end
        endcase
    end

    assign vr_next = (FW+1)'(r_ch) + (FW+1)'(s7_m_reg);
    assign vg_next = (FW+1)'(g_ch) + (FW+1)'(s7_m_reg);
    assign vb_next = (FW+1)'(b_ch) + (FW+1)'(s7_m_reg);

    logic [FW:0]      s8_vr_reg, s8_vg_reg, s8_vb_reg;

    // Stage 9: scale by 255, drop the fraction and clamp at 255.
    function automatic logic [COLOR_W-1:0] scale_out(input logic [FW:0] v);
        logic [FW+8:0] scaled;
        logic [FW+8:0] whole;
        scaled = {v, 8'b0} - (FW+9)'(v);
        whole  = scaled >> F;
        return (whole > (FW+9)'(255)) ? COLOR_W'(255) : COLOR_W'(whole);
    endfunction

    logic [COLOR_W-1:0] red_next, green_next, blue_next;

    assign red_next   = scale_out(s8_vr_reg);
    assign green_next = scale_out(s8_vg_reg);
    assign blue_next  = scale_out(s8_vb_reg);

    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg;

    assign rgb_out.red   = red_reg;
    assign rgb_out.green = green_reg;
    assign rgb_out.blue  = blue_reg;

    // Payload registers of all stages; each stage moves with its load enable.
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_sa_reg  <= sa_next;
            s1_la_reg  <= la_next;
            s1_sb_reg  <= sb_next;
            s1_lb_reg  <= lb_next;
            s1_sec_reg <= sec_next;
            s1_w_reg   <= w_next;
        end
        if (load[1])
        begin
            s2_s_reg   <= s_next;
            s2_l_reg   <= l_next;
            s2_sec_reg <= s1_sec_reg;
            s2_w_reg   <= s1_w_reg;
        end
        if (load[2])
        begin
            s3_omt_reg <= omt_next;
            s3_s_reg   <= s2_s_reg;
            s3_l_reg   <= s2_l_reg;
            s3_sec_reg <= s2_sec_reg;
            s3_w_reg   <= s2_w_reg;
        end
        if (load[3])
        begin
            s4_c_reg   <= c_next;
            s4_l_reg   <= s3_l_reg;
            s4_sec_reg <= s3_sec_reg;
            s4_w_reg   <= s3_w_reg;
        end
        if (load[4])
        begin
            s5_xp_reg  <= xp_next;
            s5_c_reg   <= s4_c_reg;
            s5_m_reg   <= m_next;
            s5_sec_reg <= s4_sec_reg;
        end
        if (load[5])
        begin
            s6_qprod_reg <= qprod_next;
            s6_y_reg     <= y_next;
            s6_c_reg     <= s5_c_reg;
            s6_m_reg     <= s5_m_reg;
            s6_sec_reg   <= s5_sec_reg;
        end
        if (load[6])
        begin
            s7_x_reg   <= x_next;
            s7_c_reg   <= s6_c_reg;
            s7_m_reg   <= s6_m_reg;
            s7_sec_reg <= s6_sec_reg;
        end
        if (load[7])
        begin
            s8_vr_reg <= vr_next;
            s8_vg_reg <= vg_next;
            s8_vb_reg <= vb_next;
        end
        if (load[8])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

`default_nettype wire
